[src/crp_pkg.sv]
package crp_pkg;

  // character codes
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned POP_W = 32;
  localparam logic [POP_W-1:0] POP_MAX = '1;

  // result queue; depth must be a power of two (pointers wrap)
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_RANK    = 4'd1,
    PH_WAITQ   = 4'd2,
    PH_NAME    = 4'd3,
    PH_WAITC   = 4'd4,
    PH_POPOPEN = 4'd5,
    PH_POP     = 4'd6,
    PH_SKIP    = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       name_byte;
    logic [POP_W-1:0] population;
    logic             last;
  } result_t;

endpackage

[src/csv_city_record_parser.sv]
// Path: a byte word accepted into the input register is parsed from there, and its
//   results are pushed into the result queue, whose head drives the outputs.
// Throughput: one byte word per cycle; a byte that yields two results (name byte
//   then line error) is absorbed by the 4-deep result queue, so input stalls only
//   when the consumer stalls.
// Reset (rst, synchronous, active high): parse phase to start of line,
//   population to zero, input register and result queue emptied.
module csv_city_record_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     data_valid,
  output logic                     data_ready,
  input  logic [7:0]               data_byte,
  input  logic                     line_end,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [1:0]               result_kind,
  output logic [7:0]               name_byte,
  output logic [crp_pkg::POP_W-1:0] population,
  output logic                     last_result
);
  import crp_pkg::*;

  // input register: holds one byte word until the queue can take its results
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eol;
  logic       step;

  result_t res0;
  result_t res1;
  result_t dout;
  logic    res0_en;
  logic    res1_en;
  logic    room2;
  logic    not_empty;
  logic    pop;

  // a byte is parsed once the queue has room for its worst case (two results)
  assign step       = in_full && room2;
  assign data_ready = !in_full || step;
  assign pop        = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (data_valid && data_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      in_byte <= data_byte;
      in_eol  <= line_end;
    end
  end

  crp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .line_end  (in_eol),
    .res0_en   (res0_en),
    .res0      (res0),
    .res1_en   (res1_en),
    .res1      (res1)
  );

  crp_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (res0_en),
    .din0      (res0),
    .push1     (res1_en),
    .din1      (res1),
    .pop       (pop),
    .dout      (dout),
    .not_empty (not_empty),
    .room2     (room2)
  );

  // result word comes straight from the queue head
  assign result_valid = not_empty;
  assign result_kind  = dout.kind;
  assign name_byte    = dout.name_byte;
  assign population   = dout.population;
  assign last_result  = dout.last;

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (in_full && !room2) |=> (in_full && $stable(in_byte) && $stable(in_eol)))
    else $error("held byte changed while queue was full");

endmodule

[src/crp_parser.sv]
module crp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              line_end,
  output logic              res0_en,
  output crp_pkg::result_t  res0,
  output logic              res1_en,
  output crp_pkg::result_t  res1
);
  import crp_pkg::*;

  phase_t           phase;
  phase_t           phase_next;
  logic [POP_W-1:0] acc;
  logic [POP_W-1:0] acc_next;

  logic             is_digit;
  logic [POP_W+3:0] prod;
  logic [POP_W-1:0] acc_sat;

  // primary result of the byte, before the line-end error
  logic             p_en;
  kind_t            p_kind;
  logic [7:0]       p_name;
  logic [POP_W-1:0] p_pop;
  logic             closed;
  logic             eol_err;

  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

  // acc * 10 + digit as (acc << 3) + (acc << 1) + digit
  assign prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
              + {{(POP_W){1'b0}}, data_byte[3:0]};
  assign acc_sat = (prod[POP_W+3:POP_W] != 4'd0) ? POP_MAX : prod[POP_W-1:0];

  // next state
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    unique case (phase)
      PH_START:   phase_next = is_digit ? PH_RANK : PH_SKIP;
      PH_RANK:    if (data_byte == CH_COMMA) phase_next = PH_WAITQ;
      PH_WAITQ:   if (data_byte == CH_QUOTE) phase_next = PH_NAME;
      PH_NAME:    if (data_byte == CH_QUOTE) phase_next = PH_WAITC;
      PH_WAITC:   if (data_byte == CH_COMMA) phase_next = PH_POPOPEN;
      PH_POPOPEN: begin
        acc_next   = '0;
        phase_next = (data_byte == CH_QUOTE) ? PH_POP : PH_SKIP;
      end
      PH_POP: begin
        if (data_byte == CH_COMMA) begin
          phase_next = PH_POP;
        end else if (is_digit) begin
          acc_next = acc_sat;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      default:    phase_next = PH_SKIP;
    endcase
    if (line_end) phase_next = PH_START;
  end

  // outputs
  always_comb begin
    p_en   = 1'b0;
    p_kind = KIND_NAME;
    p_name = '0;
    p_pop  = '0;
    closed = 1'b0;
    unique case (phase)
      PH_START: begin
        if (!is_digit) begin
          p_en   = 1'b1;
          p_kind = KIND_ERROR;
          closed = 1'b1;
        end
      end
      PH_NAME: begin
        if (data_byte != CH_QUOTE) begin
          p_en   = 1'b1;
          p_kind = KIND_NAME;
          p_name = data_byte;
        end
      end
      PH_POPOPEN: begin
        if (data_byte != CH_QUOTE) begin
          p_en   = 1'b1;
          p_kind = KIND_ACCEPT;
          closed = 1'b1;
        end
      end
      PH_POP: begin
        if (data_byte != CH_COMMA && !is_digit) begin
          p_en   = 1'b1;
          p_kind = KIND_ACCEPT;
          p_pop  = acc;
          closed = 1'b1;
        end
      end
      PH_RANK, PH_WAITQ, PH_WAITC: closed = 1'b0;
      default:                     closed = 1'b1;
    endcase

    eol_err = line_end && !closed;

    res1    = '{kind: KIND_ERROR, name_byte: 8'd0, population: '0, last: 1'b1};
    res1_en = step && p_en && eol_err;
    if (p_en) begin
      res0    = '{kind: p_kind, name_byte: p_name, population: p_pop, last: !eol_err};
      res0_en = step;
    end else begin
      res0    = '{kind: KIND_ERROR, name_byte: 8'd0, population: '0, last: 1'b1};
      res0_en = step && eol_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      acc   <= '0;
    end else if (step) begin
      phase <= phase_next;
      acc   <= acc_next;
    end
  end

  a_second_is_error: assert property (@(posedge clk) disable iff (rst)
    res1_en |-> (res0_en && res1.kind == KIND_ERROR && !res0.last))
    else $error("second result without first, or not an error");

  a_sat_holds: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_POP && acc == POP_MAX) |=> (acc == POP_MAX))
    else $error("saturated population left the maximum");

endmodule

[src/crp_res_fifo.sv]
module crp_res_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push0,
  input  crp_pkg::result_t  din0,
  input  logic              push1,
  input  crp_pkg::result_t  din1,
  input  logic              pop,
  output crp_pkg::result_t  dout,
  output logic              not_empty,
  output logic              room2
);
  import crp_pkg::*;

  result_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wptr;
  logic [FIFO_PTR_W-1:0]  wptr1;
  logic [FIFO_PTR_W-1:0]  rptr;
  logic [FIFO_CNT_W-1:0]  count;
  logic [FIFO_CNT_W-1:0]  count_next;

  assign wptr1      = wptr + FIFO_PTR_W'(1);
  assign not_empty  = (count != '0);
  assign room2      = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign dout       = mem[rptr];
  assign count_next = count + FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1)
                    - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push0) mem[wptr] <= din0;
    if (push1) mem[wptr1] <= din1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) rptr <= rptr + FIFO_PTR_W'(1);
      if (push1)      wptr <= wptr + FIFO_PTR_W'(2);
      else if (push0) wptr <= wptr1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push1 |-> (push0 && room2))
    else $error("second push without first or without room");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty result queue");

endmodule
